>>> hdl/sdc_pkg.sv
// Shared types, constants and the sector remap for the SVPWM duty calculator.
package sdc_pkg;

  localparam int HALF_SQRT3_Q16 = 56756;
  localparam int TIME_FRAC      = 12;
  localparam int DIV_STAGES     = 28;

  localparam logic [15:0] PERIOD_RST = 16'd4000;
  localparam logic [31:0] GAIN_RST   = 32'd0;

  localparam logic [0:0] CFG_PERIOD = 1'b0;
  localparam logic [0:0] CFG_GAIN   = 1'b1;

  localparam logic [2:0] SEC_ZERO = 3'd0;
  localparam logic [2:0] SEC_I    = 3'd1;
  localparam logic [2:0] SEC_II   = 3'd2;
  localparam logic [2:0] SEC_III  = 3'd3;
  localparam logic [2:0] SEC_IV   = 3'd4;
  localparam logic [2:0] SEC_V    = 3'd5;
  localparam logic [2:0] SEC_VI   = 3'd6;

  // active times and flags that ride alongside the divider
  typedef struct packed {
    logic [30:0] t1;
    logic [30:0] t2;
    logic        over;
    logic [2:0]  sector;
  } side_t;

  function automatic logic [2:0] sector_of_code(input logic [2:0] code);
    logic [2:0] s;
    case (code)
      3'd1:    s = SEC_II;
      3'd2:    s = SEC_VI;
      3'd3:    s = SEC_I;
      3'd4:    s = SEC_IV;
      3'd5:    s = SEC_III;
      3'd6:    s = SEC_V;
      default: s = SEC_ZERO;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/sdc_front.sv
// Projections, sector decode, active times and divider dividend products.
module sdc_front (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [15:0] alpha_voltage_i,
  input  logic [15:0] beta_voltage_i,
  input  logic [15:0] period_i,
  input  logic [31:0] gain_i,
  output logic        valid_o,
  output logic [59:0] x1_o,
  output logic [59:0] x2_o,
  output logic [31:0] divisor_o,
  output sdc_pkg::side_t side_o
);
  import sdc_pkg::*;

  // stage 1: projections and sector
  logic signed [33:0] k_alpha, pa, pb, pc, bh;
  logic [2:0]  code;
  logic [31:0] ma_d, mb_d, mc_d;
  logic [31:0] ma_q, mb_q, mc_q;
  logic [2:0]  sec1_q, sec2_q, sec3_q;
  logic [4:0]  vld_q;

  always_comb begin
    k_alpha = $signed({{18{alpha_voltage_i[15]}}, alpha_voltage_i})
            * $signed(34'(HALF_SQRT3_Q16));
    pa = $signed({{2{beta_voltage_i[15]}}, beta_voltage_i, 16'b0});
    bh = $signed({{3{beta_voltage_i[15]}}, beta_voltage_i, 15'b0});
    pb = k_alpha - bh;
    pc = -k_alpha - bh;
    code = {pc > 34'sd0, pb > 34'sd0, pa > 34'sd0};
    ma_d = pa[33] ? 32'(-pa) : pa[31:0];
    mb_d = pb[33] ? 32'(-pb) : pb[31:0];
    mc_d = pc[33] ? 32'(-pc) : pc[31:0];
  end

  // stage 2: split-gain products
  logic [47:0] hia_q, hib_q, hic_q, loa_q, lob_q, loc_q;
  logic [47:0] hi_g, lo_g;
  assign hi_g = 48'(gain_i[31:16]);
  assign lo_g = 48'(gain_i[15:0]);

  // stage 3: active times
  logic [48:0] sa, sb, sc;
  logic [30:0] ta_q, tb_q, tc_q;
  assign sa = 49'(hia_q) + 49'(loa_q[47:16]);
  assign sb = 49'(hib_q) + 49'(lob_q[47:16]);
  assign sc = 49'(hic_q) + 49'(loc_q[47:16]);

  // stage 4: pick the two active times
  logic [30:0] t1_d, t2_d;
  logic [31:0] sum_d, sum_q;
  logic [27:0] full;
  side_t       side4_q, side5_q;
  assign full = {period_i, 12'b0};

  always_comb begin
    case (sec3_q)
      SEC_I:   begin t1_d = tb_q; t2_d = ta_q; end
      SEC_II:  begin t1_d = tb_q; t2_d = tc_q; end
      SEC_III: begin t1_d = ta_q; t2_d = tc_q; end
      SEC_IV:  begin t1_d = ta_q; t2_d = tb_q; end
      SEC_V:   begin t1_d = tc_q; t2_d = tb_q; end
      default: begin t1_d = tc_q; t2_d = ta_q; end
    endcase
    sum_d = 32'(t1_d) + 32'(t2_d);
  end

  // stage 5: dividends for proportional scaling
  logic [59:0] x1_q, x2_q;
  logic [31:0] div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q   <= ma_d;
      mb_q   <= mb_d;
      mc_q   <= mc_d;
      sec1_q <= sector_of_code(code);
      hia_q  <= hi_g * 48'(ma_q);
      hib_q  <= hi_g * 48'(mb_q);
      hic_q  <= hi_g * 48'(mc_q);
      loa_q  <= lo_g * 48'(ma_q);
      lob_q  <= lo_g * 48'(mb_q);
      loc_q  <= lo_g * 48'(mc_q);
      sec2_q <= sec1_q;
      ta_q   <= sa[48:18];
      tb_q   <= sb[48:18];
      tc_q   <= sc[48:18];
      sec3_q <= sec2_q;
      side4_q.t1     <= t1_d;
      side4_q.t2     <= t2_d;
      side4_q.over   <= (sec3_q != SEC_ZERO) && (sum_d > 32'(full));
      side4_q.sector <= sec3_q;
      sum_q  <= sum_d;
      x1_q   <= 60'(side4_q.t1) * 60'(full);
      x2_q   <= 60'(side4_q.t2) * 60'(full);
      div_q  <= sum_q;
      side5_q <= side4_q;
    end
  end

  assign valid_o   = vld_q[4];
  assign x1_o      = x1_q;
  assign x2_o      = x2_q;
  assign divisor_o = div_q;
  assign side_o    = side5_q;

endmodule

>>> hdl/sdc_div.sv
// Pipelined restoring divider, one quotient bit per stage for both times.
module sdc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [59:0] x1_i,
  input  logic [59:0] x2_i,
  input  logic [31:0] divisor_i,
  input  sdc_pkg::side_t side_i,
  output logic        valid_o,
  output logic [27:0] q1_o,
  output logic [27:0] q2_o,
  output sdc_pkg::side_t side_o
);
  import sdc_pkg::*;

  typedef struct packed {
    logic [31:0] r1;
    logic [31:0] r2;
    logic [27:0] xl1;
    logic [27:0] xl2;
    logic [27:0] q1;
    logic [27:0] q2;
    logic [31:0] d;
    side_t       side;
  } div_t;

  function automatic logic [32:0] div_step(input logic [31:0] r, input logic b,
                                           input logic [31:0] d);
    logic [32:0] r2;
    logic        ge;
    r2 = {r, b};
    ge = r2 >= {1'b0, d};
    return {ge, ge ? 32'(r2 - {1'b0, d}) : r2[31:0]};
  endfunction

  div_t stage_in [DIV_STAGES];
  div_t stage_q  [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_q;

  // partial remainder starts from the top of the dividend (below divisor whenever it is nonzero)
  always_comb begin
    stage_in[0].r1   = x1_i[59:28];
    stage_in[0].r2   = x2_i[59:28];
    stage_in[0].xl1  = x1_i[27:0];
    stage_in[0].xl2  = x2_i[27:0];
    stage_in[0].q1   = '0;
    stage_in[0].q2   = '0;
    stage_in[0].d    = divisor_i;
    stage_in[0].side = side_i;
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    div_t        nxt;
    logic [32:0] s1, s2;

    if (i > 0) begin : g_link
      assign stage_in[i] = stage_q[i-1];
    end

    always_comb begin
      s1  = div_step(stage_in[i].r1, stage_in[i].xl1[DIV_STAGES-1-i], stage_in[i].d);
      s2  = div_step(stage_in[i].r2, stage_in[i].xl2[DIV_STAGES-1-i], stage_in[i].d);
      nxt = stage_in[i];
      nxt.r1 = s1[31:0];
      nxt.r2 = s2[31:0];
      nxt.q1 = {stage_in[i].q1[26:0], s1[32]};
      nxt.q2 = {stage_in[i].q2[26:0], s2[32]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[i] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[DIV_STAGES-1];
  assign q1_o    = stage_q[DIV_STAGES-1].q1;
  assign q2_o    = stage_q[DIV_STAGES-1].q2;
  assign side_o  = stage_q[DIV_STAGES-1].side;

endmodule

>>> hdl/sdc_back.sv
// Compare value build, saturation, phase ordering and output register.
module sdc_back (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [27:0] q1_i,
  input  logic [27:0] q2_i,
  input  sdc_pkg::side_t side_i,
  input  logic [15:0] period_i,
  output logic        valid_o,
  output logic [15:0] duty_a_o,
  output logic [15:0] duty_b_o,
  output logic [15:0] duty_c_o,
  output logic [2:0]  sector_number_o,
  output logic        over_modulated_o
);
  import sdc_pkg::*;

  logic [30:0] tt1, tt2;
  logic [31:0] rest;
  logic [20:0] v1_d, v2_d, v3_d;
  logic [20:0] v1_q, v2_q, v3_q;
  logic [2:0]  sec_q;
  logic        over_q;
  logic [1:0]  vld_q;

  always_comb begin
    tt1  = side_i.over ? 31'(q1_i) : side_i.t1;
    tt2  = side_i.over ? 31'(q2_i) : side_i.t2;
    rest = 32'({period_i, 12'b0}) - 32'(tt1) - 32'(tt2);
    v1_d = 21'(rest[27:13]);
    v2_d = v1_d + 21'(tt1[30:12]);
    v3_d = v2_d + 21'(tt2[30:12]);
  end

  logic [15:0] s1, s2, s3, half;
  logic [15:0] da_d, db_d, dc_d;
  logic [15:0] da_q, db_q, dc_q;
  logic [2:0]  sec_out_q;
  logic        over_out_q;

  assign half = period_i >> 1;

  always_comb begin
    s1 = (v1_q > 21'(period_i)) ? period_i : v1_q[15:0];
    s2 = (v2_q > 21'(period_i)) ? period_i : v2_q[15:0];
    s3 = (v3_q > 21'(period_i)) ? period_i : v3_q[15:0];
    case (sec_q)
      SEC_ZERO: begin da_d = half; db_d = half; dc_d = half; end
      SEC_I:    begin da_d = s1;   db_d = s2;   dc_d = s3;   end
      SEC_II:   begin da_d = s2;   db_d = s1;   dc_d = s3;   end
      SEC_III:  begin da_d = s3;   db_d = s1;   dc_d = s2;   end
      SEC_IV:   begin da_d = s3;   db_d = s2;   dc_d = s1;   end
      SEC_V:    begin da_d = s2;   db_d = s3;   dc_d = s1;   end
      default:  begin da_d = s1;   db_d = s3;   dc_d = s2;   end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q       <= v1_d;
      v2_q       <= v2_d;
      v3_q       <= v3_d;
      sec_q      <= side_i.sector;
      over_q     <= side_i.over;
      da_q       <= da_d;
      db_q       <= db_d;
      dc_q       <= dc_d;
      sec_out_q  <= sec_q;
      over_out_q <= over_q;
    end
  end

  assign valid_o          = vld_q[1];
  assign duty_a_o         = da_q;
  assign duty_b_o         = db_q;
  assign duty_c_o         = dc_q;
  assign sector_number_o  = sec_out_q;
  assign over_modulated_o = over_out_q;

endmodule

>>> hdl/svpwm_duty_calculator_unit.sv
// SVPWM duty calculator: alpha/beta vector in, three compare values out.
// Input channel: in_valid_i/in_ready_o carry one request of alpha_voltage_i
// and beta_voltage_i (signed Q1.14). Output channel: out_valid_o/out_ready_i
// carry duty_a_o, duty_b_o, duty_c_o, sector_number_o and over_modulated_o.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 = pwm period, 1 = voltage gain Q16.16); write only while idle.
// The pipeline has 5 front stages (projections, gain products, times,
// time pick, dividends), 28 one-quotient-bit divider stages, 2 output stages.
// Throughput is one request per cycle unless the receiver stalls; the divider
// pipeline runs on every request whether or not scaling is needed.
// Reset clears all valid bits and loads period 4000 and gain 0.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops; nothing is lost or repeated.
module svpwm_duty_calculator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] alpha_voltage_i,
  input  logic [15:0] beta_voltage_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] duty_a_o,
  output logic [15:0] duty_b_o,
  output logic [15:0] duty_c_o,
  output logic [2:0]  sector_number_o,
  output logic        over_modulated_o
);
  import sdc_pkg::*;

  logic [15:0] period_q;
  logic [31:0] gain_q;
  logic        en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      gain_q   <= GAIN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_PERIOD) begin
        period_q <= cfg_wdata_i[15:0];
      end else if (cfg_idx_i == CFG_GAIN) begin
        gain_q <= cfg_wdata_i;
      end
    end
  end

  assign en         = ~out_valid_o | out_ready_i;
  assign in_ready_o = en;

  logic        f_valid;
  logic [59:0] f_x1, f_x2;
  logic [31:0] f_div;
  side_t       f_side;

  sdc_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .alpha_voltage_i, .beta_voltage_i,
    .period_i(period_q), .gain_i(gain_q),
    .valid_o(f_valid), .x1_o(f_x1), .x2_o(f_x2), .divisor_o(f_div), .side_o(f_side)
  );

  logic        d_valid;
  logic [27:0] d_q1, d_q2;
  side_t       d_side;

  sdc_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid),
    .x1_i(f_x1), .x2_i(f_x2), .divisor_i(f_div), .side_i(f_side),
    .valid_o(d_valid), .q1_o(d_q1), .q2_o(d_q2), .side_o(d_side)
  );

  sdc_back u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_valid),
    .q1_i(d_q1), .q2_i(d_q2), .side_i(d_side), .period_i(period_q),
    .valid_o(out_valid_o), .duty_a_o, .duty_b_o, .duty_c_o,
    .sector_number_o, .over_modulated_o
  );

endmodule
